### rtl/core/refraction_direction_macros.svh
// assertion macros for the refraction direction block
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef REFRACTION_DIRECTION_MACROS_SVH
`define REFRACTION_DIRECTION_MACROS_SVH

// same-cycle implication, held off while in reset
`define RFD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define RFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rfd_pkg.sv
// shared widths, constants and types for the refraction direction block
// no dependencies; imported by every module of the block
`default_nettype none

package rfd_pkg;

    // fixed point format and field widths
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 18;
    localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN   = -(1 << (OUT_W - 1));

    // stream packing
    localparam int IN_TDATA_W  = 8 * IN_W;
    localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

    // intermediate widths
    localparam int PROD_W = 2 * IN_W;                  // 16x16 product
    localparam int NCP_W  = PROD_W + 1;                // unsigned x signed product
    localparam int OM_W   = PROD_W - FRAC_BITS + 2;    // 1 - c^2
    localparam int NSQ_W  = PROD_W - FRAC_BITS;        // n^2
    localparam int DP_W   = NSQ_W + 1 + OM_W;          // n^2 (1 - c^2)
    localparam int DISC_W = DP_W - FRAC_BITS + 1;
    localparam int RAD_W  = DISC_W - 1 + FRAC_BITS;    // clamped disc scaled up
    localparam int NC_W   = NCP_W - FRAC_BITS;         // n*c and n*d after shift
    localparam int DOT_W  = PROD_W + 2;
    localparam int DOTM_W = DOT_W + IN_W;
    localparam int RT_W   = DOTM_W - (2 * FRAC_BITS - 1) + 1;

    // square root pipeline, a few result bits per stage
    localparam int SQ_PER_STAGE = 3;
    localparam int SQ_ITERS     = (((RAD_W + 1) / 2 + SQ_PER_STAGE - 1) / SQ_PER_STAGE)
                                  * SQ_PER_STAGE;
    localparam int SQ_STAGES    = SQ_ITERS / SQ_PER_STAGE;
    localparam int SQ_PAD_W     = 2 * SQ_ITERS;
    localparam int ROOT_W       = SQ_ITERS;
    localparam int REM_W        = ROOT_W + 3;

    localparam int K_W    = ((NC_W > ROOT_W + 1) ? NC_W : ROOT_W + 1) + 1;
    localparam int KM_W   = K_W + IN_W;
    localparam int SUM_W  = ((KM_W - FRAC_BITS + 2) > (RT_W + 1)) ?
                            (KM_W - FRAC_BITS + 2) : (RT_W + 1);

    // stage counts of the front and back ends
    localparam int FR_STAGES = 4;
    localparam int BK_STAGES = 3;

    typedef logic [2:0][IN_W-1:0] t_vec_in;
    typedef logic [2:0][OUT_W-1:0] t_vec_out;

    // per-item data that rides alongside the square root
    typedef struct packed {
        logic                  tir;
        logic                  refl;
        logic [NC_W-1:0]       nc;
        logic [2:0][NC_W-1:0]  nd;
        logic [2:0][IN_W-1:0]  m;
        logic [2:0][SUM_W-1:0] rv;
    } t_side;

endpackage

`default_nettype wire

### rtl/core/rfd_front.sv
// front end: products, discriminant, radicand and mirror reflection vector
// depends on rfd_pkg
`default_nettype none

module rfd_front
    import rfd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire t_vec_in                  i_dir,
    input  wire t_vec_in                  i_norm,
    input  wire logic [IN_W-1:0]          i_ratio,
    input  wire logic signed [IN_W-1:0]   i_cos,
    input  wire logic                     i_no_fb,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output t_side                         o_side,
    output logic [RAD_W-1:0]              o_rad
);

    logic [FR_STAGES-1:0] r_v;
    logic [FR_STAGES-1:0] n_v;
    logic [FR_STAGES:0]   w_en;

    // stage 1 registers
    t_vec_in                  r_s1_d;
    t_vec_in                  r_s1_m;
    logic                     r_s1_nf;
    logic [PROD_W-1:0]        r_s1_nn;
    logic signed [PROD_W-1:0] r_s1_cc;
    logic signed [NCP_W-1:0]  r_s1_nc;
    logic signed [NCP_W-1:0]  r_s1_nd [3];
    logic signed [PROD_W-1:0] r_s1_dm [3];
    logic [PROD_W-1:0]        n_s1_nn;
    logic signed [PROD_W-1:0] n_s1_cc;
    logic signed [NCP_W-1:0]  n_s1_nc;
    logic signed [NCP_W-1:0]  n_s1_nd [3];
    logic signed [PROD_W-1:0] n_s1_dm [3];

    // stage 2 registers
    t_vec_in                  r_s2_d;
    t_vec_in                  r_s2_m;
    logic                     r_s2_nf;
    logic signed [DP_W-1:0]   r_s2_dp;
    logic signed [DOT_W-1:0]  r_s2_dot;
    logic [NC_W-1:0]          r_s2_nc;
    logic [2:0][NC_W-1:0]     r_s2_nd;
    logic signed [OM_W-1:0]   w_om;
    logic signed [DP_W-1:0]   n_s2_dp;
    logic signed [DOT_W-1:0]  n_s2_dot;
    logic [NC_W-1:0]          n_s2_nc;
    logic [2:0][NC_W-1:0]     n_s2_nd;

    // stage 3 registers
    t_vec_in                  r_s3_d;
    t_vec_in                  r_s3_m;
    logic                     r_s3_tir;
    logic                     r_s3_refl;
    logic [RAD_W-1:0]         r_s3_rad;
    logic signed [DOTM_W-1:0] r_s3_dotm [3];
    logic [NC_W-1:0]          r_s3_nc;
    logic [2:0][NC_W-1:0]     r_s3_nd;
    logic signed [DISC_W-1:0] w_disc;
    logic                     w_tir;
    logic [RAD_W-1:0]         n_s3_rad;
    logic signed [DOTM_W-1:0] n_s3_dotm [3];

    // stage 4 registers
    t_side                    r_s4_side;
    logic [RAD_W-1:0]         r_s4_rad;
    t_side                    n_s4_side;

    // stall chain: a stage loads when empty or when the next one moves
    always_comb begin
        w_en[FR_STAGES] = i_ready;
        for (int k = FR_STAGES - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
        n_v[0] = w_en[0] ? i_valid : r_v[0];
        for (int k = 1; k < FR_STAGES; k++) begin
            n_v[k] = w_en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // stage 1: all 16x16 products
    always_comb begin
        n_s1_nn = PROD_W'(i_ratio) * PROD_W'(i_ratio);
        n_s1_cc = PROD_W'(i_cos) * PROD_W'(i_cos);
        n_s1_nc = NCP_W'($signed({1'b0, i_ratio})) * NCP_W'(i_cos);
        for (int i = 0; i < 3; i++) begin
            n_s1_nd[i] = NCP_W'($signed({1'b0, i_ratio})) * NCP_W'($signed(i_dir[i]));
            n_s1_dm[i] = PROD_W'($signed(i_dir[i])) * PROD_W'($signed(i_norm[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_d  <= i_dir;
            r_s1_m  <= i_norm;
            r_s1_nf <= i_no_fb;
            r_s1_nn <= n_s1_nn;
            r_s1_cc <= n_s1_cc;
            r_s1_nc <= n_s1_nc;
            for (int i = 0; i < 3; i++) begin
                r_s1_nd[i] <= n_s1_nd[i];
                r_s1_dm[i] <= n_s1_dm[i];
            end
        end
    end

    // stage 2: n^2 (1 - c^2), the dot product, and n*c and n*d scaled down
    always_comb begin
        w_om     = OM_W'(ONE) - OM_W'(r_s1_cc >>> FRAC_BITS);
        n_s2_dp  = DP_W'($signed({1'b0, r_s1_nn[PROD_W-1:FRAC_BITS]})) * DP_W'(w_om);
        n_s2_dot = DOT_W'(r_s1_dm[0]) + DOT_W'(r_s1_dm[1]) + DOT_W'(r_s1_dm[2]);
        n_s2_nc  = NC_W'(r_s1_nc >>> FRAC_BITS);
        for (int i = 0; i < 3; i++) begin
            n_s2_nd[i] = NC_W'(r_s1_nd[i] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_d   <= r_s1_d;
            r_s2_m   <= r_s1_m;
            r_s2_nf  <= r_s1_nf;
            r_s2_dp  <= n_s2_dp;
            r_s2_dot <= n_s2_dot;
            r_s2_nc  <= n_s2_nc;
            r_s2_nd  <= n_s2_nd;
        end
    end

    // stage 3: discriminant, clamp to zero, dot product times normal
    always_comb begin
        w_disc   = DISC_W'(ONE) - DISC_W'(r_s2_dp >>> FRAC_BITS);
        w_tir    = w_disc[DISC_W-1];
        n_s3_rad = w_tir ? '0 : {w_disc[DISC_W-2:0], {FRAC_BITS{1'b0}}};
        for (int i = 0; i < 3; i++) begin
            n_s3_dotm[i] = DOTM_W'(r_s2_dot) * DOTM_W'($signed(r_s2_m[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_d    <= r_s2_d;
            r_s3_m    <= r_s2_m;
            r_s3_tir  <= w_tir;
            r_s3_refl <= w_tir && !r_s2_nf;
            r_s3_rad  <= n_s3_rad;
            r_s3_nc   <= r_s2_nc;
            r_s3_nd   <= r_s2_nd;
            for (int i = 0; i < 3; i++) begin
                r_s3_dotm[i] <= n_s3_dotm[i];
            end
        end
    end

    // stage 4: mirror vector d - 2 (d.m) m
    always_comb begin
        n_s4_side.tir  = r_s3_tir;
        n_s4_side.refl = r_s3_refl;
        n_s4_side.nc   = r_s3_nc;
        n_s4_side.nd   = r_s3_nd;
        n_s4_side.m    = r_s3_m;
        for (int i = 0; i < 3; i++) begin
            n_s4_side.rv[i] = SUM_W'($signed(r_s3_d[i]))
                            - SUM_W'(r_s3_dotm[i] >>> (2 * FRAC_BITS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_side <= n_s4_side;
            r_s4_rad  <= r_s3_rad;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[FR_STAGES-1];
    assign o_side  = r_s4_side;
    assign o_rad   = r_s4_rad;

endmodule

`default_nettype wire

### rtl/core/rfd_sqrt.sv
// pipelined integer square root, a few result bits per stage
// depends on rfd_pkg; carries the per-item side data along
`default_nettype none

module rfd_sqrt
    import rfd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [RAD_W-1:0]     i_rad,
    input  wire t_side                i_side,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [ROOT_W-1:0]         o_root,
    output t_side                     o_side
);

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [ROOT_W-1:0]   root;
        logic [SQ_PAD_W-1:0] rad;
    } t_sq;

    logic [SQ_STAGES-1:0] r_v;
    logic [SQ_STAGES-1:0] n_v;
    logic [SQ_STAGES:0]   w_en;
    t_sq                  r_sq [SQ_STAGES];
    t_sq                  n_sq [SQ_STAGES];
    t_sq                  w_sq_in [SQ_STAGES];
    t_side                r_side [SQ_STAGES];
    t_side                w_side_in [SQ_STAGES];

    // one restoring step: bring down two radicand bits, try root*4+1
    function automatic t_sq sq_step(input t_sq a);
        t_sq              b;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        rem2  = {a.rem[REM_W-3:0], a.rad[SQ_PAD_W-1 -: 2]};
        trial = {1'b0, a.root, 2'b01};
        b.rad = {a.rad[SQ_PAD_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            b.rem  = rem2 - trial;
            b.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            b.rem  = rem2;
            b.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return b;
    endfunction

    // stall chain and valid bits
    always_comb begin
        w_en[SQ_STAGES] = i_ready;
        for (int k = SQ_STAGES - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
        n_v[0] = w_en[0] ? i_valid : r_v[0];
        for (int k = 1; k < SQ_STAGES; k++) begin
            n_v[k] = w_en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // stage inputs and per-stage iterations
    always_comb begin
        for (int s = 0; s < SQ_STAGES; s++) begin
            if (s == 0) begin
                w_sq_in[s].rem  = '0;
                w_sq_in[s].root = '0;
                w_sq_in[s].rad  = SQ_PAD_W'(i_rad);
                w_side_in[s]    = i_side;
            end else begin
                w_sq_in[s]   = r_sq[s-1];
                w_side_in[s] = r_side[s-1];
            end
            n_sq[s] = w_sq_in[s];
            for (int j = 0; j < SQ_PER_STAGE; j++) begin
                n_sq[s] = sq_step(n_sq[s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQ_STAGES; s++) begin
            if (w_en[s]) begin
                r_sq[s]   <= n_sq[s];
                r_side[s] <= w_side_in[s];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_sq[SQ_STAGES-1].root;
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/rfd_back.sv
// back end: refraction coefficient, final products, select and saturate
// depends on rfd_pkg; its last stage is the output register
`default_nettype none

module rfd_back
    import rfd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [ROOT_W-1:0]    i_root,
    input  wire t_side                i_side,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_vec_out                  o_out,
    output logic                      o_tir
);

    logic [BK_STAGES-1:0]    r_v;
    logic [BK_STAGES-1:0]    n_v;
    logic [BK_STAGES:0]      w_en;

    logic signed [K_W-1:0]   r_k;
    logic signed [K_W-1:0]   n_k;
    t_side                   r_s1_side;
    logic signed [KM_W-1:0]  r_km [3];
    logic signed [KM_W-1:0]  n_km [3];
    t_side                   r_s2_side;
    logic signed [SUM_W-1:0] w_sum [3];
    t_vec_out                r_out;
    t_vec_out                n_out;
    logic                    r_tir;

    // clamp to the signed output range
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] s);
        if (s > SUM_W'(OUT_MAX)) begin
            return OUT_W'(OUT_MAX);
        end else if (s < SUM_W'(OUT_MIN)) begin
            return OUT_W'(OUT_MIN);
        end
        return s[OUT_W-1:0];
    endfunction

    // stall chain and valid bits
    always_comb begin
        w_en[BK_STAGES] = i_ready;
        for (int k = BK_STAGES - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
        n_v[0] = w_en[0] ? i_valid : r_v[0];
        for (int k = 1; k < BK_STAGES; k++) begin
            n_v[k] = w_en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // stage 1: k = n*c - sqrt(disc)
    assign n_k = K_W'($signed(i_side.nc)) - K_W'($signed({1'b0, i_root}));

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_k       <= n_k;
            r_s1_side <= i_side;
        end
    end

    // stage 2: k times normal
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_km[i] = KM_W'(r_k) * KM_W'($signed(r_s1_side.m[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_side <= r_s1_side;
            for (int i = 0; i < 3; i++) begin
                r_km[i] <= n_km[i];
            end
        end
    end

    // stage 3: refracted or mirrored vector, saturated
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_s2_side.refl) begin
                w_sum[i] = $signed(r_s2_side.rv[i]);
            end else begin
                w_sum[i] = SUM_W'($signed(r_s2_side.nd[i])) + SUM_W'(r_km[i] >>> FRAC_BITS);
            end
            n_out[i] = sat_out(w_sum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_out <= n_out;
            r_tir <= r_s2_side.tir;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[BK_STAGES-1];
    assign o_out   = r_out;
    assign o_tir   = r_tir;

endmodule

`default_nettype wire

### rtl/core/refraction_direction.sv
// Refraction direction, top level.
// Slave stream carries one ray per transaction: tdata holds dir_x, dir_y,
// dir_z, norm_x, norm_y, norm_z (signed Q1.14), index_ratio (unsigned
// Q2.14) and incidence_cos (signed Q1.14) from the lowest bit up; tuser[0]
// is no_fallback. Master stream gives one result per ray: tdata holds
// out_x, out_y, out_z (signed Q3.14, saturated) from the lowest bit up,
// topped with zeros; tuser[0] is total_reflect.
// Fourteen register stages: four front stages (products, discriminant,
// radicand, mirror vector), seven square root stages of three result bits
// each, three back stages. Throughput is one transaction per cycle while
// the master side takes results; every stage holds a valid bit, so empty
// stages fill up while the master side is stalled and the slave side stops
// only once every stage holds a result. A stalled result stays in the
// output register unchanged. Reset clears all valid bits; no transaction
// is in flight afterwards.
// Depends on rfd_pkg, rfd_front, rfd_sqrt, rfd_back and the macros header.
`default_nettype none

`include "refraction_direction_macros.svh"

module refraction_direction
    import rfd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio, incidence_cos
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // no_fallback
    input  wire logic [0:0]              s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // out_x, out_y, out_z, zero padding
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
    // total_reflect
    output logic [0:0]                   m_axis_tuser
);

    t_vec_in            w_dir;
    t_vec_in            w_norm;
    logic               w_fr_valid;
    t_side              w_fr_side;
    logic [RAD_W-1:0]   w_fr_rad;
    logic               w_sq_ready;
    logic               w_sq_valid;
    logic [ROOT_W-1:0]  w_sq_root;
    t_side              w_sq_side;
    logic               w_bk_ready;
    t_vec_out           w_out;
    logic               w_tir;

    // unpack the input transaction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dir[i]  = s_axis_tdata[i*IN_W +: IN_W];
            w_norm[i] = s_axis_tdata[(3+i)*IN_W +: IN_W];
        end
    end

    rfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_dir   (w_dir),
        .i_norm  (w_norm),
        .i_ratio (s_axis_tdata[6*IN_W +: IN_W]),
        .i_cos   ($signed(s_axis_tdata[7*IN_W +: IN_W])),
        .i_no_fb (s_axis_tuser[0]),
        .o_valid (w_fr_valid),
        .i_ready (w_sq_ready),
        .o_side  (w_fr_side),
        .o_rad   (w_fr_rad)
    );

    rfd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_sq_ready),
        .i_rad   (w_fr_rad),
        .i_side  (w_fr_side),
        .o_valid (w_sq_valid),
        .i_ready (w_bk_ready),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    rfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .o_ready (w_bk_ready),
        .i_root  (w_sq_root),
        .i_side  (w_sq_side),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_out   (w_out),
        .o_tir   (w_tir)
    );

    // pack the output transaction
    assign m_axis_tdata    = {{(OUT_TDATA_W - 3 * OUT_W){1'b0}}, w_out};
    assign m_axis_tuser[0] = w_tir;

    // checks on the pipeline
    `RFD_ASSERT_IMPLY(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled although the output side moves")
    `RFD_ASSERT_IMPLY(a_reflect_needs_tir, w_fr_valid && w_fr_side.refl, w_fr_side.tir, "mirror path chosen without total internal reflection")
    `RFD_ASSERT_IMPLY(a_tir_zero_radicand, w_fr_valid && w_fr_side.tir, w_fr_rad == '0, "negative discriminant not clamped to zero")
    `RFD_ASSERT_NEXT(a_sqrt_hold, w_sq_valid && !w_bk_ready, w_sq_valid && $stable(w_sq_root), "square root result lost under stall")

endmodule

`default_nettype wire
